// File: rtl/bfa_pkg.sv
// Package for the block fit allocator: table sizes, field widths, status and mode codes,
// and the table port structs.
// No dependencies; every other file of the block uses it.
package bfa_pkg;

  // Table geometry.
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Beat field widths.
  localparam int SIZE_W      = 16;
  localparam int FREE_IDX_W  = 6;
  localparam int OUT_IDX_W   = 6;
  localparam int STATUS_W    = 3;
  localparam int MODE_W      = 2;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Operation codes of an input beat.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Placement policies; the fourth code behaves as first fit.
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 3'd4;

  // Word address bit that selects the register file; fit_mode is register 0.
  localparam logic REG_FIT_MODE = 1'b0;

  // Write command into the block table.
  typedef struct packed {
    logic              size_en;
    logic              used_en;
    logic [IDX_W-1:0]  addr;
    logic [SIZE_W-1:0] size;
    logic              used;
  } tbl_wr_t;

  // Read command into the block table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

endpackage

// File: rtl/bfa_ifs.sv
// Handshake interfaces for the request and response channels of the allocator.
// Depends on bfa_pkg for the field widths.
interface bfa_req_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [bfa_pkg::SIZE_W-1:0]      request_size;
  logic [bfa_pkg::FREE_IDX_W-1:0]  free_index;

  modport source (output valid, output kind, output request_size, output free_index,
                  input ready);
  modport sink   (input valid, input kind, input request_size, input free_index,
                  output ready);
endinterface

interface bfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::OUT_IDX_W-1:0]  block_index;
  logic [bfa_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output block_index, output status, input ready);
  modport sink   (input valid, input block_index, input status, output ready);
endinterface

// File: rtl/bfa_table.sv
// Block table storage: one memory of block sizes and one of used marks, each with
// a single write port and a single registered read port. Depends on bfa_pkg.
module bfa_table (
  input  logic                        clk,
  input  bfa_pkg::tbl_wr_t            wr,
  input  bfa_pkg::tbl_rd_t            rd,
  output logic [bfa_pkg::SIZE_W-1:0]  rd_size,
  output logic                        rd_used
);

  logic [bfa_pkg::SIZE_W-1:0] size_mem [bfa_pkg::MAX_BLOCKS];
  logic                       used_mem [bfa_pkg::MAX_BLOCKS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.size_en) begin
      size_mem[wr.addr] <= wr.size;
    end
    if (wr.used_en) begin
      used_mem[wr.addr] <= wr.used;
    end
  end

  // Registered read port; data appears the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_size <= size_mem[rd.addr];
      rd_used <= used_mem[rd.addr];
    end
  end

endmodule

// File: rtl/block_fit_allocator.sv
// Block fit allocator top level: request sequencer, table scan with one shared compare,
// response register and APB configuration register. Depends on bfa_pkg, bfa_ifs, bfa_table.
//
//   Channel  Direction  Carries                             Handshake
//   req      in         kind, request_size, free_index      valid/ready
//   rsp      out        block_index, status                 valid/ready
//   apb      in/out     fit_mode (register 0)               psel/penable, pready high
//
// A free goes straight to the decision and loads its response once the response register
// is free. An allocate reads the table one entry per cycle through the single read port,
// from the start index (0, or the cursor in next fit) to the block count, then decides.
// In the cycle after the response is loaded the sequencer is idle and can take the next beat.
// Reset clears the block count, cursor, fit_mode and all handshake state; table
// contents are not cleared. req.ready is high only while the sequencer is idle, and a
// finished result waits in the response register while the next beat is taken.
module block_fit_allocator (
  input  logic                          clk,
  input  logic                          rst,
  bfa_req_if.sink                       req,
  bfa_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [bfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [bfa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                            state;
  logic [bfa_pkg::MODE_W-1:0]        fit_mode;
  logic [bfa_pkg::MODE_W-1:0]        mode;
  logic                              kind;
  logic [bfa_pkg::SIZE_W-1:0]        req_size;
  logic [bfa_pkg::FREE_IDX_W-1:0]    free_idx;
  logic [bfa_pkg::CNT_W-1:0]         count;
  logic [bfa_pkg::IDX_W-1:0]         cursor;
  logic [bfa_pkg::CNT_W-1:0]         issue_idx;
  logic                              pend_valid;
  logic [bfa_pkg::IDX_W-1:0]         pend_idx;
  logic                              found;
  logic [bfa_pkg::IDX_W-1:0]         pick;
  logic [bfa_pkg::SIZE_W-1:0]        best_size;
  logic                              out_valid;
  logic [bfa_pkg::OUT_IDX_W-1:0]     out_index;
  logic [bfa_pkg::STATUS_W-1:0]      out_status;

  bfa_pkg::tbl_wr_t                  wr;
  bfa_pkg::tbl_rd_t                  rd;
  logic [bfa_pkg::SIZE_W-1:0]        rd_size;
  logic                              rd_used;

  logic                              accept;
  logic                              cfg_write;
  logic                              issue;
  logic                              fits;
  logic                              take;
  logic                              load;
  logic                              free_ok;
  logic                              full;
  logic [bfa_pkg::OUT_IDX_W-1:0]     res_index;
  logic [bfa_pkg::STATUS_W-1:0]      res_status;
  logic                              move_cursor;
  logic                              append;

  bfa_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_size (rd_size),
    .rd_used (rd_used)
  );

  // Configuration port: writes complete in the access phase, reads return fit_mode for register 0 and zero otherwise.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[bfa_pkg::PADDR_W-1] == bfa_pkg::REG_FIT_MODE)
                     ? bfa_pkg::PDATA_W'(fit_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= bfa_pkg::MODE_FIRST;
    end else if (cfg_write && paddr[bfa_pkg::PADDR_W-1] == bfa_pkg::REG_FIT_MODE) begin
      fit_mode <= pwdata[bfa_pkg::MODE_W-1:0];
    end
  end

  // Handshake on the request side.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Scan: issue one table read per cycle, then judge each returned entry in the cycle after its read.
  assign issue   = (state == S_SCAN) && (issue_idx < count);
  assign rd.en   = issue;
  assign rd.addr = bfa_pkg::IDX_W'(issue_idx);
  assign fits    = pend_valid && !rd_used && (rd_size >= req_size);
  assign take    = fits && (!found || (mode == bfa_pkg::MODE_BEST && rd_size < best_size));

  // Decision once the scan is over or for a free.
  assign load    = (state == S_DONE) && (!out_valid || rsp.ready);
  assign free_ok = (bfa_pkg::CNT_W'(free_idx) < count);
  assign full    = (count == bfa_pkg::CNT_W'(bfa_pkg::MAX_BLOCKS));

  always_comb begin
    res_index   = '0;
    res_status  = bfa_pkg::ST_BAD_FREE;
    move_cursor = 1'b0;
    append      = 1'b0;
    wr.size_en  = 1'b0;
    wr.used_en  = 1'b0;
    wr.addr     = pick;
    wr.size     = req_size;
    wr.used     = 1'b1;
    if (kind == bfa_pkg::KIND_FREE) begin
      wr.addr = bfa_pkg::IDX_W'(free_idx);
      wr.used = 1'b0;
      if (free_ok) begin
        res_index  = bfa_pkg::OUT_IDX_W'(free_idx);
        res_status = bfa_pkg::ST_FREED;
        wr.used_en = load;
      end
    end else if (found) begin
      res_index   = bfa_pkg::OUT_IDX_W'(pick);
      res_status  = bfa_pkg::ST_REUSED;
      wr.used_en  = load;
      move_cursor = (mode == bfa_pkg::MODE_NEXT);
    end else if (full) begin
      res_status = bfa_pkg::ST_FULL;
    end else begin
      wr.addr     = bfa_pkg::IDX_W'(count);
      res_index   = bfa_pkg::OUT_IDX_W'(count);
      res_status  = bfa_pkg::ST_APPENDED;
      wr.size_en  = load;
      wr.used_en  = load;
      append      = 1'b1;
      move_cursor = (mode == bfa_pkg::MODE_NEXT);
    end
  end

  // Sequencer and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      cursor     <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            found      <= 1'b0;
            pend_valid <= 1'b0;
            issue_idx  <= (fit_mode == bfa_pkg::MODE_NEXT) ? bfa_pkg::CNT_W'(cursor) : '0;
            state      <= (req.kind == bfa_pkg::KIND_FREE) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          pend_valid <= issue;
          pend_idx   <= rd.addr;
          if (issue) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (take) begin
            found     <= 1'b1;
            pick      <= pend_idx;
            best_size <= rd_size;
          end
          if (!issue && !pend_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            if (append) begin
              count <= count + 1'b1;
            end
            if (move_cursor) begin
              cursor <= wr.addr;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request fields held for the length of the operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind     <= req.kind;
      req_size <= req.request_size;
      free_idx <= req.free_index;
      mode     <= (fit_mode == bfa_pkg::MODE_NEXT || fit_mode == bfa_pkg::MODE_BEST)
                  ? fit_mode : bfa_pkg::MODE_FIRST;
    end
  end

  // Response register: holds one finished beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_index  <= res_index;
      out_status <= res_status;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.block_index = out_index;
  assign rsp.status      = out_status;

endmodule
